[design/vmfd_pkg.sv]
// shared types, constants and arithmetic helpers for the view matrix pipeline
package vmfd_pkg;

  // restoring square root steps and divide quotient bits
  localparam int ROOT_STEPS = 32;
  localparam int QUO_BITS   = 31;

  localparam logic [63:0] RND_HALF = 64'h0000_0000_2000_0000;

  typedef logic [2:0][63:0] vmfd_vec64_t;
  typedef logic [2:0][31:0] vmfd_vec32_t;

  // data that rides along a normalizer: eye position and one companion vector
  typedef struct packed {
    vmfd_vec32_t e;
    vmfd_vec32_t a;
  } vmfd_side_t;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } vmfd_in_t;

  typedef struct packed {
    logic signed [31:0] side_x;
    logic signed [31:0] side_y;
    logic signed [31:0] side_z;
    logic signed [31:0] upaxis_x;
    logic signed [31:0] upaxis_y;
    logic signed [31:0] upaxis_z;
    logic signed [31:0] fwd_x;
    logic signed [31:0] fwd_y;
    logic signed [31:0] fwd_z;
    logic signed [39:0] shift_side;
    logic signed [39:0] shift_up;
    logic signed [39:0] shift_fwd;
  } vmfd_out_t;

  // signed 32x32 product
  function automatic logic signed [63:0] smul(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    sa = 64'($signed(a));
    sb = 64'($signed(b));
    return sa * sb;
  endfunction

  // shift right by 30, round half away from zero
  function automatic logic signed [63:0] round30(input logic signed [63:0] x);
    logic [63:0] m;
    m = x[63] ? 64'(-x) : 64'(x);
    m = (m + RND_HALF) >> 30;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

[design/vmfd_norm.sv]
// pipelined vector normalizer: scale, sum of squares, square root, per-lane divide
module vmfd_norm import vmfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  vmfd_vec64_t in_c,
  input  vmfd_side_t  in_sb,
  output logic        out_vld,
  output vmfd_vec32_t out_o,
  output vmfd_side_t  out_sb
);

  // stage a: magnitudes and signs
  logic        a_vld_r;
  vmfd_vec64_t a_m_r;
  logic [2:0]  a_neg_r;
  vmfd_side_t  a_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
    end
    for (int i = 0; i < 3; i++) begin
      a_neg_r[i] <= in_c[i][63];
      a_m_r[i]   <= in_c[i][63] ? (64'd0 - in_c[i]) : in_c[i];
    end
    a_sb_r <= in_sb;
  end

  // stage b: largest magnitude
  logic        b_vld_r;
  vmfd_vec64_t b_m_r;
  logic [2:0]  b_neg_r;
  vmfd_side_t  b_sb_r;
  logic [63:0] b_big_r;
  logic [63:0] big_nxt;

  always_comb begin
    big_nxt = a_m_r[0];
    if (a_m_r[1] > big_nxt) begin
      big_nxt = a_m_r[1];
    end
    if (a_m_r[2] > big_nxt) begin
      big_nxt = a_m_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_m_r   <= a_m_r;
    b_neg_r <= a_neg_r;
    b_sb_r  <= a_sb_r;
    b_big_r <= big_nxt;
  end

  // stage c: leading one position
  logic        c_vld_r;
  vmfd_vec64_t c_m_r;
  logic [2:0]  c_neg_r;
  vmfd_side_t  c_sb_r;
  logic [63:0] c_big_r;
  logic [5:0]  c_p_r;
  logic        c_zero_r;
  logic [5:0]  lead_nxt;

  always_comb begin
    lead_nxt = 6'd0;
    for (int k = 0; k < 64; k++) begin
      if (b_big_r[k]) begin
        lead_nxt = 6'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
    c_m_r    <= b_m_r;
    c_neg_r  <= b_neg_r;
    c_sb_r   <= b_sb_r;
    c_big_r  <= b_big_r;
    c_p_r    <= lead_nxt;
    c_zero_r <= (b_big_r == 64'd0);
  end

  // stage d: shift amount that brings the largest into [2^30, 2^31]
  logic        d_vld_r;
  vmfd_vec64_t d_m_r;
  logic [2:0]  d_neg_r;
  vmfd_side_t  d_sb_r;
  logic        d_zero_r;
  logic [5:0]  d_rs_r;
  logic [5:0]  d_ls_r;
  logic [5:0]  rs_nxt;
  logic [5:0]  ls_nxt;
  logic [63:0] top_bits;

  always_comb begin
    top_bits = c_big_r >> (c_p_r - 6'd31);
    rs_nxt   = 6'd0;
    ls_nxt   = 6'd0;
    if (c_p_r >= 6'd31) begin
      // exactly 2^31 after the shift needs one step less
      if (top_bits == 64'h0000_0000_8000_0000) begin
        rs_nxt = c_p_r - 6'd31;
      end else begin
        rs_nxt = c_p_r - 6'd30;
      end
    end else begin
      ls_nxt = 6'd30 - c_p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= c_vld_r;
    end
    d_m_r    <= c_m_r;
    d_neg_r  <= c_neg_r;
    d_sb_r   <= c_sb_r;
    d_zero_r <= c_zero_r;
    d_rs_r   <= rs_nxt;
    d_ls_r   <= ls_nxt;
  end

  // stage e: apply common shift
  logic        e_vld_r;
  vmfd_vec32_t e_m_r;
  logic [2:0]  e_neg_r;
  vmfd_side_t  e_sb_r;
  logic        e_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= d_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      e_m_r[i] <= 32'((d_m_r[i] << d_ls_r) >> d_rs_r);
    end
    e_neg_r  <= d_neg_r;
    e_sb_r   <= d_sb_r;
    e_zero_r <= d_zero_r;
  end

  // stage f: squares
  logic        f_vld_r;
  vmfd_vec32_t f_m_r;
  vmfd_vec64_t f_sq_r;
  logic [2:0]  f_neg_r;
  vmfd_side_t  f_sb_r;
  logic        f_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= e_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      f_sq_r[i] <= 64'(e_m_r[i]) * 64'(e_m_r[i]);
    end
    f_m_r    <= e_m_r;
    f_neg_r  <= e_neg_r;
    f_sb_r   <= e_sb_r;
    f_zero_r <= e_zero_r;
  end

  // square root pipeline, one restoring step per stage
  logic        sq_vld_r  [ROOT_STEPS+1];
  logic [33:0] sq_rem_r  [ROOT_STEPS+1];
  logic [31:0] sq_root_r [ROOT_STEPS+1];
  logic [63:0] sq_n_r    [ROOT_STEPS+1];
  vmfd_vec32_t sq_m_r    [ROOT_STEPS+1];
  logic [2:0]  sq_neg_r  [ROOT_STEPS+1];
  logic        sq_zero_r [ROOT_STEPS+1];
  vmfd_side_t  sq_sb_r   [ROOT_STEPS+1];
  logic [35:0] rt_sh     [ROOT_STEPS];
  logic [35:0] rt_trial  [ROOT_STEPS];
  logic [ROOT_STEPS-1:0] rt_ge;

  always_comb begin
    for (int k = 0; k < ROOT_STEPS; k++) begin
      rt_sh[k]    = {sq_rem_r[k], sq_n_r[k][63:62]};
      rt_trial[k] = {2'b00, sq_root_r[k], 2'b01};
      rt_ge[k]    = (rt_sh[k] >= rt_trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= ROOT_STEPS; k++) begin
        sq_vld_r[k] <= 1'b0;
      end
    end else begin
      sq_vld_r[0] <= f_vld_r;
      for (int k = 0; k < ROOT_STEPS; k++) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end
    sq_rem_r[0]  <= 34'd0;
    sq_root_r[0] <= 32'd0;
    sq_n_r[0]    <= f_sq_r[0] + f_sq_r[1] + f_sq_r[2];
    sq_m_r[0]    <= f_m_r;
    sq_neg_r[0]  <= f_neg_r;
    sq_zero_r[0] <= f_zero_r;
    sq_sb_r[0]   <= f_sb_r;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      sq_rem_r[k+1]  <= rt_ge[k] ? 34'(rt_sh[k] - rt_trial[k]) : rt_sh[k][33:0];
      sq_root_r[k+1] <= {sq_root_r[k][30:0], rt_ge[k]};
      sq_n_r[k+1]    <= {sq_n_r[k][61:0], 2'b00};
      sq_m_r[k+1]    <= sq_m_r[k];
      sq_neg_r[k+1]  <= sq_neg_r[k];
      sq_zero_r[k+1] <= sq_zero_r[k];
      sq_sb_r[k+1]   <= sq_sb_r[k];
    end
  end

  // divide pipeline: (m * 2^30 + r/2) / r, one quotient bit per stage
  logic             dv_vld_r  [QUO_BITS+1];
  logic [2:0][32:0] dv_rem_r  [QUO_BITS+1];
  logic [2:0][30:0] dv_low_r  [QUO_BITS+1];
  logic [2:0][30:0] dv_q_r    [QUO_BITS+1];
  logic [31:0]      dv_r_r    [QUO_BITS+1];
  logic [2:0]       dv_neg_r  [QUO_BITS+1];
  logic             dv_zero_r [QUO_BITS+1];
  vmfd_side_t       dv_sb_r   [QUO_BITS+1];
  logic [2:0][32:0] dv_sh     [QUO_BITS];
  logic [2:0]       dv_ge     [QUO_BITS];
  logic [2:0][61:0] dv_num;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_num[i] = {sq_m_r[ROOT_STEPS][i], 30'd0} + 62'(sq_root_r[ROOT_STEPS] >> 1);
    end
    for (int j = 0; j < QUO_BITS; j++) begin
      for (int i = 0; i < 3; i++) begin
        dv_sh[j][i] = {dv_rem_r[j][i][31:0], dv_low_r[j][i][30]};
        dv_ge[j][i] = (dv_sh[j][i] >= {1'b0, dv_r_r[j]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QUO_BITS; j++) begin
        dv_vld_r[j] <= 1'b0;
      end
    end else begin
      dv_vld_r[0] <= sq_vld_r[ROOT_STEPS];
      for (int j = 0; j < QUO_BITS; j++) begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
    end
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= {2'b00, dv_num[i][61:31]};
      dv_low_r[0][i] <= dv_num[i][30:0];
      dv_q_r[0][i]   <= 31'd0;
    end
    dv_r_r[0]    <= sq_root_r[ROOT_STEPS];
    dv_neg_r[0]  <= sq_neg_r[ROOT_STEPS];
    dv_zero_r[0] <= sq_zero_r[ROOT_STEPS];
    dv_sb_r[0]   <= sq_sb_r[ROOT_STEPS];
    for (int j = 0; j < QUO_BITS; j++) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[j+1][i] <= dv_ge[j][i] ? (dv_sh[j][i] - {1'b0, dv_r_r[j]}) : dv_sh[j][i];
        dv_low_r[j+1][i] <= {dv_low_r[j][i][29:0], 1'b0};
        dv_q_r[j+1][i]   <= {dv_q_r[j][i][29:0], dv_ge[j][i]};
      end
      dv_r_r[j+1]    <= dv_r_r[j];
      dv_neg_r[j+1]  <= dv_neg_r[j];
      dv_zero_r[j+1] <= dv_zero_r[j];
      dv_sb_r[j+1]   <= dv_sb_r[j];
    end
  end

  // output stage: restore signs, zero vector gives zero axis
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= dv_vld_r[QUO_BITS];
    end
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_r[QUO_BITS]) begin
        out_o[i] <= 32'd0;
      end else if (dv_neg_r[QUO_BITS][i]) begin
        out_o[i] <= 32'd0 - {1'b0, dv_q_r[QUO_BITS][i]};
      end else begin
        out_o[i] <= {1'b0, dv_q_r[QUO_BITS][i]};
      end
    end
    out_sb <= dv_sb_r[QUO_BITS];
  end

endmodule

[design/view_matrix_from_direction_core.sv]
// camera view basis pipeline: forward, side and up axes with translations
// throughput: one request per cycle, set by the fully pipelined normalizers
// busy is always low and results are never held back by the receiver
// reset: synchronous active-low rst_n clears all stage valid bits
module view_matrix_from_direction_core import vmfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  vmfd_in_t  in_data,
  output logic      out_strobe,
  output vmfd_out_t out_data
);

  assign busy = 1'b0;

  // forward axis normalizer
  vmfd_vec64_t n1_c;
  vmfd_side_t  n1_sb;
  logic        n1_vld;
  vmfd_vec32_t n1_f;
  vmfd_side_t  n1_sb_o;

  assign n1_c[0]    = 64'(in_data.dir_x);
  assign n1_c[1]    = 64'(in_data.dir_y);
  assign n1_c[2]    = 64'(in_data.dir_z);
  assign n1_sb.e[0] = in_data.eye_x;
  assign n1_sb.e[1] = in_data.eye_y;
  assign n1_sb.e[2] = in_data.eye_z;
  assign n1_sb.a[0] = in_data.up_x;
  assign n1_sb.a[1] = in_data.up_y;
  assign n1_sb.a[2] = in_data.up_z;

  vmfd_norm u_norm_fwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start),
    .in_c    (n1_c),
    .in_sb   (n1_sb),
    .out_vld (n1_vld),
    .out_o   (n1_f),
    .out_sb  (n1_sb_o)
  );

  // cross product f x up: products
  logic            x1_vld_r;
  logic [5:0][63:0] x1_p_r;
  vmfd_vec32_t     x1_f_r;
  vmfd_vec32_t     x1_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_vld_r <= 1'b0;
    end else begin
      x1_vld_r <= n1_vld;
    end
    x1_p_r[0] <= smul(n1_f[1], n1_sb_o.a[2]);
    x1_p_r[1] <= smul(n1_f[2], n1_sb_o.a[1]);
    x1_p_r[2] <= smul(n1_f[2], n1_sb_o.a[0]);
    x1_p_r[3] <= smul(n1_f[0], n1_sb_o.a[2]);
    x1_p_r[4] <= smul(n1_f[0], n1_sb_o.a[1]);
    x1_p_r[5] <= smul(n1_f[1], n1_sb_o.a[0]);
    x1_f_r    <= n1_f;
    x1_e_r    <= n1_sb_o.e;
  end

  // cross product differences
  logic        x2_vld_r;
  vmfd_vec64_t x2_c_r;
  vmfd_side_t  x2_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x2_vld_r <= 1'b0;
    end else begin
      x2_vld_r <= x1_vld_r;
    end
    x2_c_r[0]  <= x1_p_r[0] - x1_p_r[1];
    x2_c_r[1]  <= x1_p_r[2] - x1_p_r[3];
    x2_c_r[2]  <= x1_p_r[4] - x1_p_r[5];
    x2_sb_r.e  <= x1_e_r;
    x2_sb_r.a  <= x1_f_r;
  end

  // side axis normalizer
  logic        n2_vld;
  vmfd_vec32_t n2_s;
  vmfd_side_t  n2_sb_o;

  vmfd_norm u_norm_side (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (x2_vld_r),
    .in_c    (x2_c_r),
    .in_sb   (x2_sb_r),
    .out_vld (n2_vld),
    .out_o   (n2_s),
    .out_sb  (n2_sb_o)
  );

  // up axis products and side/forward dot products
  logic             v1_vld_r;
  logic [5:0][63:0] v1_p_r;
  vmfd_vec64_t      v1_se_r;
  vmfd_vec64_t      v1_fe_r;
  vmfd_vec32_t      v1_s_r;
  vmfd_vec32_t      v1_f_r;
  vmfd_vec32_t      v1_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_vld_r <= 1'b0;
    end else begin
      v1_vld_r <= n2_vld;
    end
    v1_p_r[0] <= smul(n2_sb_o.a[1], n2_s[2]);
    v1_p_r[1] <= smul(n2_sb_o.a[2], n2_s[1]);
    v1_p_r[2] <= smul(n2_sb_o.a[2], n2_s[0]);
    v1_p_r[3] <= smul(n2_sb_o.a[0], n2_s[2]);
    v1_p_r[4] <= smul(n2_sb_o.a[0], n2_s[1]);
    v1_p_r[5] <= smul(n2_sb_o.a[1], n2_s[0]);
    for (int i = 0; i < 3; i++) begin
      v1_se_r[i] <= smul(n2_s[i], n2_sb_o.e[i]);
      v1_fe_r[i] <= smul(n2_sb_o.a[i], n2_sb_o.e[i]);
    end
    v1_s_r <= n2_s;
    v1_f_r <= n2_sb_o.a;
    v1_e_r <= n2_sb_o.e;
  end

  // differences and sums
  logic        v2_vld_r;
  vmfd_vec64_t v2_v_r;
  logic [63:0] v2_ds_r;
  logic [63:0] v2_df_r;
  vmfd_vec32_t v2_s_r;
  vmfd_vec32_t v2_f_r;
  vmfd_vec32_t v2_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_vld_r <= 1'b0;
    end else begin
      v2_vld_r <= v1_vld_r;
    end
    v2_v_r[0] <= v1_p_r[0] - v1_p_r[1];
    v2_v_r[1] <= v1_p_r[2] - v1_p_r[3];
    v2_v_r[2] <= v1_p_r[4] - v1_p_r[5];
    v2_ds_r   <= v1_se_r[0] + v1_se_r[1] + v1_se_r[2];
    v2_df_r   <= v1_fe_r[0] + v1_fe_r[1] + v1_fe_r[2];
    v2_s_r    <= v1_s_r;
    v2_f_r    <= v1_f_r;
    v2_e_r    <= v1_e_r;
  end

  // rounding of up axis and side/forward translations
  logic        v3_vld_r;
  vmfd_vec32_t v3_v_r;
  logic [39:0] v3_ts_r;
  logic [39:0] v3_tf_r;
  vmfd_vec32_t v3_s_r;
  vmfd_vec32_t v3_f_r;
  vmfd_vec32_t v3_e_r;
  logic signed [63:0] ts_nxt;
  logic signed [63:0] tf_nxt;

  assign ts_nxt = -round30(v2_ds_r);
  assign tf_nxt = -round30(v2_df_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_vld_r <= 1'b0;
    end else begin
      v3_vld_r <= v2_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      v3_v_r[i] <= 32'(round30(v2_v_r[i]));
    end
    v3_ts_r <= ts_nxt[39:0];
    v3_tf_r <= tf_nxt[39:0];
    v3_s_r  <= v2_s_r;
    v3_f_r  <= v2_f_r;
    v3_e_r  <= v2_e_r;
  end

  // up axis dot products
  logic        v4_vld_r;
  vmfd_vec64_t v4_ve_r;
  vmfd_vec32_t v4_v_r;
  logic [39:0] v4_ts_r;
  logic [39:0] v4_tf_r;
  vmfd_vec32_t v4_s_r;
  vmfd_vec32_t v4_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_vld_r <= 1'b0;
    end else begin
      v4_vld_r <= v3_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      v4_ve_r[i] <= smul(v3_v_r[i], v3_e_r[i]);
    end
    v4_v_r  <= v3_v_r;
    v4_ts_r <= v3_ts_r;
    v4_tf_r <= v3_tf_r;
    v4_s_r  <= v3_s_r;
    v4_f_r  <= v3_f_r;
  end

  // up axis dot sum
  logic        v5_vld_r;
  logic [63:0] v5_dv_r;
  vmfd_vec32_t v5_v_r;
  logic [39:0] v5_ts_r;
  logic [39:0] v5_tf_r;
  vmfd_vec32_t v5_s_r;
  vmfd_vec32_t v5_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_vld_r <= 1'b0;
    end else begin
      v5_vld_r <= v4_vld_r;
    end
    v5_dv_r <= v4_ve_r[0] + v4_ve_r[1] + v4_ve_r[2];
    v5_v_r  <= v4_v_r;
    v5_ts_r <= v4_ts_r;
    v5_tf_r <= v4_tf_r;
    v5_s_r  <= v4_s_r;
    v5_f_r  <= v4_f_r;
  end

  // output register
  logic signed [63:0] tv_nxt;

  assign tv_nxt = -round30(v5_dv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= v5_vld_r;
    end
    out_data.side_x     <= v5_s_r[0];
    out_data.side_y     <= v5_s_r[1];
    out_data.side_z     <= v5_s_r[2];
    out_data.upaxis_x   <= v5_v_r[0];
    out_data.upaxis_y   <= v5_v_r[1];
    out_data.upaxis_z   <= v5_v_r[2];
    out_data.fwd_x      <= v5_f_r[0];
    out_data.fwd_y      <= v5_f_r[1];
    out_data.fwd_z      <= v5_f_r[2];
    out_data.shift_side <= v5_ts_r;
    out_data.shift_up   <= tv_nxt[39:0];
    out_data.shift_fwd  <= v5_tf_r;
  end

endmodule
